// File: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define QEBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qebd assertion failed");

// Checked on every clock edge, reset included.
`define QEBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qebd assertion failed");

`endif

// File: sv/qebd_pkg.sv
`default_nettype none
package qebd_pkg;

  localparam int HP_LEN     = 5;
  localparam int ENERGY_LEN = 30;
  // post-shift tap of the sample one older than the center of the high-pass window
  localparam int CENTER_TAP = (HP_LEN + 1) / 2;

  localparam int SAMPLE_W  = 16;
  localparam int HP_W      = 18;
  localparam int HSUM_W    = 24;
  localparam int ENERGY_W  = 40;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int PART_W    = ENERGY_W / 2;
  localparam int COEF_W    = CFG_W + 1;
  localparam int PART_PROD_W = COEF_W + PART_W;
  localparam int ACC_W     = COEF_W + ENERGY_W;
  localparam int EACC_W    = ENERGY_W + 2;
  localparam int SC_W      = PROD_W - 16;
  localparam int DIFF_W    = SC_W + 1;
  localparam int FRAC_W    = 16;

  localparam int HP_LIM    = 131071;
  localparam int SUM_MAX   = 8388607;
  localparam int SUM_MIN   = -8388608;
  localparam int HALF      = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_COEF,
    CFG_ALPHA,
    CFG_GAMMA,
    CFG_WINDOW_LEN,
    CFG_HOLDOFF_LEN
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] hp_coef;
    logic [CFG_W-1:0] alpha;
    logic [CFG_W-1:0] gamma;
    logic [CFG_W-1:0] window_len;
    logic [CFG_W-1:0] holdoff_len;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_HP,
    OP_SQUARE,
    OP_ENERGY,
    OP_DECIDE,
    OP_AG,
    OP_T2LO,
    OP_T2HI,
    OP_T1LO,
    OP_T1HI,
    OP_T1SUM,
    OP_THRESH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_HP,
    ST_SQUARE,
    ST_ENERGY,
    ST_DECIDE,
    ST_AG,
    ST_T2LO,
    ST_T2HI,
    ST_T1LO,
    ST_T1HI,
    ST_T1SUM,
    ST_THRESH
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic window_end;
  } status_t;

endpackage
`default_nettype wire

// File: sv/qrs_energy_beat_detector.sv
// QRS beat detector on a moving-average high-pass filter and a sliding
// energy feature, one ECG sample per request.
// Input channel: in_valid / in_stall with in_ecg_sample (16 bit signed).
// A request is taken when in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with out_beat and out_energy
// (40 bit feature); one result per input request, in order.
// Config channel: cfg_valid / cfg_ready, cfg_index selects hp_coef, alpha,
// gamma, window_len or holdoff_len; other indexes are ignored. Write only
// while no request is in flight.
// A taken request passes the scale, high-pass, square, energy and decision
// steps; the decision step writes the result to the output register. One
// shared 18x24 multiplier runs the filter, the two squares and, on a sample
// that closes an adaptation window, the threshold update in turn.
// Stall: a stalled full output register holds the block in its decision
// step; in_stall stays high until the block is idle again.
// Reset (rst_n low, synchronous) clears the running sums, counters, the threshold
// and the output valid, and loads the register defaults.
`default_nettype none
module qrs_energy_beat_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [qebd_pkg::SAMPLE_W-1:0] in_ecg_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_beat,
  output logic [qebd_pkg::ENERGY_W-1:0]        out_energy,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qebd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qebd_pkg::CFG_W-1:0]           cfg_data
);
  import qebd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  qebd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qebd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  qebd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .in_ecg_sample (in_ecg_sample),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_beat      (out_beat),
    .out_energy    (out_energy)
  );

endmodule
`default_nettype wire

// File: sv/qebd_cfg.sv
`default_nettype none
module qebd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qebd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qebd_pkg::CFG_W-1:0]     cfg_data,
  output qebd_pkg::cfg_t                 cfg
);
  import qebd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hp_coef     <= CFG_W'(13107);
      cfg_r.alpha       <= CFG_W'(3277);
      cfg_r.gamma       <= CFG_W'(11469);
      cfg_r.window_len  <= CFG_W'(360);
      cfg_r.holdoff_len <= CFG_W'(72);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HP_COEF:     cfg_r.hp_coef     <= cfg_data;
        CFG_ALPHA:       cfg_r.alpha       <= cfg_data;
        CFG_GAMMA:       cfg_r.gamma       <= cfg_data;
        CFG_WINDOW_LEN:  cfg_r.window_len  <= cfg_data;
        CFG_HOLDOFF_LEN: cfg_r.holdoff_len <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/qebd_ctrl.sv
`default_nettype none
module qebd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output qebd_pkg::cmd_t    cmd,
  input  qebd_pkg::status_t status
);
  import qebd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_HP;
      ST_HP:     state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ENERGY;
      ST_ENERGY: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        // hold until the output register can take the result
        if (status.out_free) state_nxt = status.window_end ? ST_AG : ST_IDLE;
      end
      ST_AG:     state_nxt = ST_T2LO;
      ST_T2LO:   state_nxt = ST_T2HI;
      ST_T2HI:   state_nxt = ST_T1LO;
      ST_T1LO:   state_nxt = ST_T1HI;
      ST_T1HI:   state_nxt = ST_T1SUM;
      ST_T1SUM:  state_nxt = ST_THRESH;
      ST_THRESH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    cmd.op   = OP_NONE;
    unique case (state_r)
      ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_SCALE:  cmd.op = OP_SCALE;
      ST_HP:     cmd.op = OP_HP;
      ST_SQUARE: cmd.op = OP_SQUARE;
      ST_ENERGY: cmd.op = OP_ENERGY;
      ST_DECIDE: cmd.op = status.out_free ? OP_DECIDE : OP_NONE;
      ST_AG:     cmd.op = OP_AG;
      ST_T2LO:   cmd.op = OP_T2LO;
      ST_T2HI:   cmd.op = OP_T2HI;
      ST_T1LO:   cmd.op = OP_T1LO;
      ST_T1HI:   cmd.op = OP_T1HI;
      ST_T1SUM:  cmd.op = OP_T1SUM;
      ST_THRESH: cmd.op = OP_THRESH;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/qebd_dpath.sv
`default_nettype none
module qebd_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  qebd_pkg::cmd_t                       cmd,
  output qebd_pkg::status_t                    status,
  input  qebd_pkg::cfg_t                       cfg,
  input  logic signed [qebd_pkg::SAMPLE_W-1:0] in_ecg_sample,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_beat,
  output logic [qebd_pkg::ENERGY_W-1:0]        out_energy
);
  import qebd_pkg::*;

  // delay lines: index 0 holds the most recent entry
  logic signed [SAMPLE_W-1:0] smp_r [HP_LEN];
  logic signed [HP_W-1:0]     hpl_r [ENERGY_LEN];

  logic signed [HSUM_W-1:0] hsum_r, hsum_nxt;
  logic signed [PROD_W-1:0] prod_r, mul_p;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [HP_W-1:0]   hp_r, hp_nxt;
  logic signed [EACC_W-1:0] eacc_r, eacc_nxt;
  logic [ENERGY_W-1:0]      esum_r, esum_nxt;
  logic [ENERGY_W-1:0]      feat_r, feat_nxt;
  logic [ENERGY_W-1:0]      thr_r, thr_nxt;
  logic [ENERGY_W-1:0]      wp_r, wp_nxt;
  logic [CNT_W-1:0]         warm_r, warm_nxt;
  logic [CNT_W-1:0]         win_r;
  logic [CNT_W-1:0]         hold_r, hold_nxt;
  logic                     blocked_r, blocked_nxt;
  logic [COEF_W-1:0]        ag_r, ag_nxt;
  logic [ACC_W-1:0]         acc_r;
  logic [ENERGY_W-1:0]      t2_r;
  logic [ENERGY_W-1:0]      thr_win;
  logic                     out_valid_r, out_beat_r;
  logic [ENERGY_W-1:0]      out_energy_r;

  logic                     hp_en, en_en, warm_act, feat_gt_thr, beat;
  logic [COEF_W-1:0]        coef_c;
  logic [PART_PROD_W-1:0]   part_p;
  logic [ACC_W-1:0]         acc_lo, acc_hi;

  assign hp_en    = (warm_r >= CNT_W'(HP_LEN));
  assign en_en    = (warm_r >= CNT_W'(ENERGY_LEN));
  assign coef_c   = {1'b1, {CFG_W{1'b0}}} - {1'b0, cfg.alpha};
  assign part_p   = prod_r[PART_PROD_W-1:0];
  assign acc_lo   = ACC_W'(part_p) + ACC_W'(HALF);
  assign acc_hi   = acc_r + ACC_W'({part_p, {PART_W{1'b0}}});

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SCALE: begin
        mul_a = $signed({2'b00, cfg.hp_coef});
        mul_b = hsum_r;
      end
      OP_HP: begin
        mul_a = hpl_r[ENERGY_LEN-1];
        mul_b = MUL_B_W'(hpl_r[ENERGY_LEN-1]);
      end
      OP_SQUARE: begin
        mul_a = hp_r;
        mul_b = MUL_B_W'(hp_r);
      end
      OP_AG: begin
        mul_a = $signed({2'b00, cfg.alpha});
        mul_b = $signed({8'h00, cfg.gamma});
      end
      OP_T2LO: begin
        mul_a = $signed({1'b0, coef_c});
        mul_b = $signed({4'h0, thr_r[PART_W-1:0]});
      end
      OP_T2HI: begin
        mul_a = $signed({1'b0, coef_c});
        mul_b = $signed({4'h0, thr_r[ENERGY_W-1:PART_W]});
      end
      OP_T1LO: begin
        mul_a = $signed({1'b0, ag_r});
        mul_b = $signed({4'h0, wp_r[PART_W-1:0]});
      end
      OP_T1HI: begin
        mul_a = $signed({1'b0, ag_r});
        mul_b = $signed({4'h0, wp_r[ENERGY_W-1:PART_W]});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // high-pass running sum
  always_comb begin
    logic signed [HSUM_W+1:0] s;
    logic signed [SAMPLE_W-1:0] oldest;
    oldest = hp_en ? smp_r[HP_LEN-1] : '0;
    s = (HSUM_W+2)'(hsum_r) + (HSUM_W+2)'(in_ecg_sample) - (HSUM_W+2)'(oldest);
    if (s > (HSUM_W+2)'(SUM_MAX))      hsum_nxt = HSUM_W'(SUM_MAX);
    else if (s < (HSUM_W+2)'(SUM_MIN)) hsum_nxt = HSUM_W'(SUM_MIN);
    else                               hsum_nxt = s[HSUM_W-1:0];
  end

  // CENTER_TAP sample minus rounded scaled sum
  always_comb begin
    logic signed [PROD_W-1:0] r;
    logic signed [SC_W-1:0]   sc;
    logic signed [DIFF_W-1:0] diff;
    r    = prod_r + PROD_W'(HALF);
    sc   = r[PROD_W-1:FRAC_W];
    diff = DIFF_W'(smp_r[CENTER_TAP]) - DIFF_W'(sc);
    if (!hp_en)                           hp_nxt = '0;
    else if (diff > DIFF_W'(HP_LIM))      hp_nxt = HP_W'(HP_LIM);
    else if (diff < -(DIFF_W'(HP_LIM)))   hp_nxt = -(HP_W'(HP_LIM));
    else                                  hp_nxt = diff[HP_W-1:0];
  end

  // energy sum: drop the oldest square, then add the newest
  always_comb begin
    logic signed [EACC_W-1:0] s;
    eacc_nxt = $signed({2'b00, esum_r}) - (en_en ? prod_r : '0);
    s = eacc_r + prod_r;
    if (s < 0)                                       esum_nxt = '0;
    else if (s > $signed({2'b00, {ENERGY_W{1'b1}}})) esum_nxt = '1;
    else                                             esum_nxt = s[ENERGY_W-1:0];
    feat_nxt = en_en ? esum_nxt : '0;
  end

  // beat decision and bookkeeping
  always_comb begin
    logic [CNT_W-1:0] hold_inc;
    warm_act    = (warm_r < cfg.window_len);
    feat_gt_thr = (feat_r > thr_r);
    thr_nxt     = (warm_act && feat_gt_thr) ? feat_r : thr_r;
    warm_nxt    = warm_act ? warm_r + CNT_W'(1) : warm_r;
    wp_nxt      = (feat_r > wp_r) ? feat_r : wp_r;
    hold_inc    = (hold_r != '1) ? hold_r + CNT_W'(1) : hold_r;
    hold_nxt    = hold_r;
    blocked_nxt = blocked_r;
    if (blocked_r) begin
      if (hold_inc >= cfg.holdoff_len) begin
        blocked_nxt = 1'b0;
        hold_nxt    = '0;
      end else begin
        hold_nxt    = hold_inc;
      end
    end
    // during warm-up the threshold already covers this feature
    beat = !warm_act && feat_gt_thr && !blocked_nxt;
  end

  // threshold adaptation helpers
  always_comb begin
    logic [COEF_W+FRAC_W-1:0] r;
    logic [ENERGY_W:0]        t;
    r       = (COEF_W+FRAC_W)'(prod_r[2*CFG_W-1:0]) + (COEF_W+FRAC_W)'(HALF);
    ag_nxt  = r[COEF_W+FRAC_W-1:FRAC_W];
    t       = {1'b0, t2_r} + {1'b0, acc_r[FRAC_W +: ENERGY_W]};
    thr_win = t[ENERGY_W] ? '1 : t[ENERGY_W-1:0];
  end

  assign status.out_free   = !out_valid_r || !out_stall;
  assign status.window_end = !beat && (win_r >= cfg.window_len);

  // ring payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      smp_r[0] <= in_ecg_sample;
      for (int k = 1; k < HP_LEN; k++) smp_r[k] <= smp_r[k-1];
    end
    if (cmd.op == OP_HP) begin
      hpl_r[0] <= hp_nxt;
      for (int k = 1; k < ENERGY_LEN; k++) hpl_r[k] <= hpl_r[k-1];
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (cmd.op)
      OP_HP:     hp_r   <= hp_nxt;
      OP_SQUARE: eacc_r <= eacc_nxt;
      OP_ENERGY: feat_r <= feat_nxt;
      OP_T2LO:   ag_r   <= ag_nxt;
      OP_T2HI:   acc_r  <= acc_lo;
      OP_T1LO:   acc_r  <= acc_hi;
      OP_T1HI: begin
        t2_r  <= acc_r[FRAC_W +: ENERGY_W];
        acc_r <= acc_lo;
      end
      OP_T1SUM:  acc_r  <= acc_hi;
      default: ;
    endcase
    if (cmd.op == OP_DECIDE) begin
      out_beat_r   <= beat;
      out_energy_r <= feat_r;
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsum_r      <= '0;
      esum_r      <= '0;
      thr_r       <= '0;
      wp_r        <= '0;
      warm_r      <= '0;
      win_r       <= '0;
      hold_r      <= '0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD:   hsum_r <= hsum_nxt;
        OP_ENERGY: esum_r <= esum_nxt;
        OP_DECIDE: begin
          thr_r     <= thr_nxt;
          warm_r    <= warm_nxt;
          wp_r      <= wp_nxt;
          hold_r    <= hold_nxt;
          blocked_r <= blocked_nxt || beat;
          if (!beat && (win_r < cfg.window_len)) win_r <= win_r + CNT_W'(1);
        end
        OP_THRESH: begin
          thr_r <= thr_win;
          win_r <= '0;
          wp_r  <= '0;
        end
        default: ;
      endcase
      if (cmd.op == OP_DECIDE)         out_valid_r <= 1'b1;
      else if (!out_stall)             out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;
  assign out_energy = out_energy_r;

endmodule
`default_nettype wire

// File: sv/qebd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module qebd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_beat,
  input logic [qebd_pkg::ENERGY_W-1:0]        out_energy
);
  import qebd_pkg::*;

  `QEBD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid)
  `QEBD_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall ##1 in_stall)
  `QEBD_ASSERT(a_beat_has_energy, out_valid |-> (!out_beat || (out_energy != '0)))
  `QEBD_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_beat) && $stable(out_energy)))

endmodule

bind qrs_energy_beat_detector qebd_checker u_qebd_checker (.*);
`default_nettype wire
